// ===== rtl/tsdlp_pkg.sv =====
// Package for the transport-stream descriptor loop parser.
// Holds field ids, register indexes, parse phases and the result record type.
// No dependencies.
package tsdlp_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTRW  = 2;

    // configuration register indexes
    localparam logic [2:0] REG_LANG = 3'd0;
    localparam logic [2:0] REG_CA   = 3'd1;
    localparam logic [2:0] REG_MB   = 3'd2;
    localparam logic [2:0] REG_AC3  = 3'd3;
    localparam logic [2:0] REG_CN   = 3'd4;

    // field ids
    localparam logic [4:0] F_TAG      = 5'd0;
    localparam logic [4:0] F_LEN      = 5'd1;
    localparam logic [4:0] F_LCODE    = 5'd2;
    localparam logic [4:0] F_ATYPE    = 5'd3;
    localparam logic [4:0] F_CASYS    = 5'd4;
    localparam logic [4:0] F_CAPID    = 5'd5;
    localparam logic [4:0] F_MAXRATE  = 5'd6;
    localparam logic [4:0] F_SRATE    = 5'd7;
    localparam logic [4:0] F_BSID     = 5'd8;
    localparam logic [4:0] F_BRATE    = 5'd9;
    localparam logic [4:0] F_SURR     = 5'd10;
    localparam logic [4:0] F_BSMOD    = 5'd11;
    localparam logic [4:0] F_NCH      = 5'd12;
    localparam logic [4:0] F_FULLSVC  = 5'd13;
    localparam logic [4:0] F_LANGCOD  = 5'd14;
    localparam logic [4:0] F_LANGCOD2 = 5'd15;
    localparam logic [4:0] F_MAINID   = 5'd16;
    localparam logic [4:0] F_PRIO     = 5'd17;
    localparam logic [4:0] F_ASVC     = 5'd18;
    localparam logic [4:0] F_TEXTLEN  = 5'd19;
    localparam logic [4:0] F_TEXTCODE = 5'd20;
    localparam logic [4:0] F_LFLAG    = 5'd21;
    localparam logic [4:0] F_LFLAG2   = 5'd22;
    localparam logic [4:0] F_AC3LANG  = 5'd23;
    localparam logic [4:0] F_NSTR     = 5'd24;
    localparam logic [4:0] F_SLANG    = 5'd25;
    localparam logic [4:0] F_NSEG     = 5'd26;
    localparam logic [4:0] F_CTYPE    = 5'd27;
    localparam logic [4:0] F_MODE     = 5'd28;
    localparam logic [4:0] F_NBYTES   = 5'd29;
    localparam logic [4:0] F_DATA     = 5'd30;
    localparam logic [4:0] F_OVERRUN  = 5'd31;

    // parse phases
    typedef enum logic [5:0] {
        P_TAG, P_LEN, P_SKIP, P_LC0, P_LC1, P_LC2, P_LAT,
        P_CA0, P_CA1, P_CA2, P_CA3, P_MB0, P_MB1, P_MB2,
        P_A0, P_A1, P_A2, P_A3, P_A4, P_A5, P_A6, P_A7, P_ATXT,
        P_AL0, P_AL1, P_AL2, P_CNS, P_CL0, P_CL1, P_CL2,
        P_CSEG, P_CCT, P_CMODE, P_CNB, P_CBYTES
    } phase_t;

    // one result
    typedef struct packed {
        logic [4:0]  id;
        logic [23:0] value;
        logic [7:0]  tag;
        logic [7:0]  entry;
        logic        desc_end;
        logic        loop_end;
        logic        run_last;
    } result_t;

    // up to three results caused by one byte
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
        result_t    r2;
    } group_t;

endpackage

// ===== rtl/tsdlp_front.sv =====
// Front part: byte-level parse state machine; turns each byte into a group
// of up to three results. Depends on tsdlp_pkg.
module tsdlp_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [7:0]               data_byte,
    input  logic                     loop_start,
    input  logic [11:0]              loop_length,
    input  logic [7:0]               language_tag,
    input  logic [7:0]               cond_access_tag,
    input  logic [7:0]               max_rate_tag,
    input  logic [7:0]               ac3_tag,
    input  logic [7:0]               comp_name_tag,
    output logic                     grp_valid,
    output tsdlp_pkg::group_t        grp
);

    logic [11:0]          loop_left_reg,  loop_left_next;
    logic [7:0]           cur_tag_reg,    cur_tag_next;
    logic [7:0]           desc_left_reg,  desc_left_next;
    tsdlp_pkg::phase_t    phase_reg,      phase_next;
    logic [23:0]          accum_reg,      accum_next;
    logic [7:0]           strl_reg,       strl_next;
    logic [7:0]           segl_reg,       segl_next;
    logic [7:0]           sbl_reg,        sbl_next;
    logic [7:0]           entry_reg,      entry_next;
    logic [2:0]           flags_reg,      flags_next;

    tsdlp_pkg::result_t   res [3];
    logic [1:0]           n;
    logic                 done;
    logic                 active;
    logic [11:0]          ll;
    logic [11:0]          ll_dec;
    tsdlp_pkg::phase_t    ph;
    logic [23:0]          shifted;
    logic [7:0]           b;
    logic [7:0]           dl;
    logic [7:0]           dleft_dec;
    logic [7:0]           tmp8;

    // pick the body phase for a tag
    function automatic tsdlp_pkg::phase_t start_phase(input logic [7:0] t,
        input logic [7:0] lt, input logic [7:0] ct, input logic [7:0] mt,
        input logic [7:0] at, input logic [7:0] nt);
        tsdlp_pkg::phase_t p;
        begin
            if (t == lt)      p = tsdlp_pkg::P_LC0;
            else if (t == ct) p = tsdlp_pkg::P_CA0;
            else if (t == mt) p = tsdlp_pkg::P_MB0;
            else if (t == at) p = tsdlp_pkg::P_A0;
            else if (t == nt) p = tsdlp_pkg::P_CNS;
            else              p = tsdlp_pkg::P_SKIP;
            return p;
        end
    endfunction

    assign b       = data_byte;
    assign shifted = {accum_reg[15:0], b};

    // compute next parse state and results
    always_comb
    begin
        loop_left_next = loop_left_reg;
        cur_tag_next   = cur_tag_reg;
        desc_left_next = desc_left_reg;
        phase_next     = phase_reg;
        accum_next     = accum_reg;
        strl_next      = strl_reg;
        segl_next      = segl_reg;
        sbl_next       = sbl_reg;
        entry_next     = entry_reg;
        flags_next     = flags_reg;
        n              = 2'd0;
        done           = 1'b0;
        dl             = 8'd0;
        tmp8           = 8'd0;
        for (int i = 0; i < 3; i++)
        begin
            res[i] = '0;
        end
        ph        = phase_reg;
        ll        = loop_left_reg;
        dleft_dec = desc_left_reg;
        if (loop_start)
        begin
            ll        = loop_length;
            ph        = tsdlp_pkg::P_TAG;
            dleft_dec = 8'd0;
        end
        active = in_valid && (ll != 12'd0);
        ll_dec = ll - 12'd1;

        if (active)
        begin
            loop_left_next = ll_dec;
            desc_left_next = dleft_dec;
            phase_next     = ph;
            if (ph == tsdlp_pkg::P_TAG)
            begin
                cur_tag_next = b;
                res[0] = '{tsdlp_pkg::F_TAG, {16'd0, b}, b, 8'd0, 1'b0, 1'b0, 1'b0};
                n = 2'd1;
                if (ll_dec == 12'd0)
                begin
                    res[1] = '{tsdlp_pkg::F_OVERRUN, 24'd0, b, 8'd0, 1'b0, 1'b0, 1'b0};
                    n = 2'd2;
                    done = 1'b1;
                end
                else
                begin
                    phase_next = tsdlp_pkg::P_LEN;
                end
            end
            else if (ph == tsdlp_pkg::P_LEN)
            begin
                dl = b;
                res[0] = '{tsdlp_pkg::F_LEN, {16'd0, b}, cur_tag_reg, 8'd0,
                           1'b0, 1'b0, 1'b0};
                n = 2'd1;
                if ({4'd0, b} > ll_dec)
                begin
                    res[1] = '{tsdlp_pkg::F_OVERRUN, {16'd0, b}, cur_tag_reg, 8'd0,
                               1'b0, 1'b0, 1'b0};
                    n = 2'd2;
                    dl = ll_dec[7:0];
                end
                desc_left_next = dl;
                entry_next = 8'd0;
                flags_next = 3'd0;
                accum_next = 24'd0;
                if (dl == 8'd0)
                    done = 1'b1;
                else
                    phase_next = start_phase(cur_tag_reg, language_tag, cond_access_tag,
                                             max_rate_tag, ac3_tag, comp_name_tag);
            end
            else
            begin
                // body byte: default result slot setup
                for (int i = 0; i < 3; i++)
                begin
                    res[i].tag = cur_tag_reg;
                end
                unique case (ph)
                    tsdlp_pkg::P_LC0:
                    begin
                        if (dleft_dec < 8'd4)
                        begin
                            phase_next = tsdlp_pkg::P_SKIP;
                            res[0].id = tsdlp_pkg::F_DATA; res[0].value = {16'd0, b};
                            n = 2'd1;
                        end
                        else
                        begin
                            accum_next = {16'd0, b};
                            phase_next = tsdlp_pkg::P_LC1;
                        end
                    end
                    tsdlp_pkg::P_LC1:
                    begin
                        accum_next = shifted; phase_next = tsdlp_pkg::P_LC2;
                    end
                    tsdlp_pkg::P_LC2:
                    begin
                        accum_next = shifted;
                        res[0].id = tsdlp_pkg::F_LCODE; res[0].value = shifted;
                        res[0].entry = entry_reg; n = 2'd1;
                        phase_next = tsdlp_pkg::P_LAT;
                    end
                    tsdlp_pkg::P_LAT:
                    begin
                        res[0].id = tsdlp_pkg::F_ATYPE; res[0].value = {16'd0, b};
                        res[0].entry = entry_reg; n = 2'd1;
                        entry_next = entry_reg + 8'd1;
                        phase_next = tsdlp_pkg::P_LC0;
                    end
                    tsdlp_pkg::P_CA0, tsdlp_pkg::P_CA2, tsdlp_pkg::P_MB0,
                    tsdlp_pkg::P_CL0, tsdlp_pkg::P_AL0:
                    begin
                        accum_next = {16'd0, b};
                        unique case (ph)
                            tsdlp_pkg::P_CA0: phase_next = tsdlp_pkg::P_CA1;
                            tsdlp_pkg::P_CA2: phase_next = tsdlp_pkg::P_CA3;
                            tsdlp_pkg::P_MB0: phase_next = tsdlp_pkg::P_MB1;
                            tsdlp_pkg::P_CL0: phase_next = tsdlp_pkg::P_CL1;
                            default:          phase_next = tsdlp_pkg::P_AL1;
                        endcase
                    end
                    tsdlp_pkg::P_CA1:
                    begin
                        accum_next = shifted;
                        res[0].id = tsdlp_pkg::F_CASYS; res[0].value = {8'd0, shifted[15:0]};
                        n = 2'd1; phase_next = tsdlp_pkg::P_CA2;
                    end
                    tsdlp_pkg::P_CA3:
                    begin
                        accum_next = shifted;
                        res[0].id = tsdlp_pkg::F_CAPID; res[0].value = {11'd0, shifted[12:0]};
                        n = 2'd1; phase_next = tsdlp_pkg::P_SKIP;
                    end
                    tsdlp_pkg::P_MB1, tsdlp_pkg::P_CL1, tsdlp_pkg::P_AL1:
                    begin
                        accum_next = shifted;
                        unique case (ph)
                            tsdlp_pkg::P_MB1: phase_next = tsdlp_pkg::P_MB2;
                            tsdlp_pkg::P_CL1: phase_next = tsdlp_pkg::P_CL2;
                            default:          phase_next = tsdlp_pkg::P_AL2;
                        endcase
                    end
                    tsdlp_pkg::P_MB2:
                    begin
                        accum_next = shifted;
                        res[0].id = tsdlp_pkg::F_MAXRATE; res[0].value = {2'd0, shifted[21:0]};
                        n = 2'd1; phase_next = tsdlp_pkg::P_SKIP;
                    end
                    tsdlp_pkg::P_A0:
                    begin
                        res[0].id = tsdlp_pkg::F_SRATE; res[0].value = {21'd0, b[7:5]};
                        res[1].id = tsdlp_pkg::F_BSID;  res[1].value = {19'd0, b[4:0]};
                        n = 2'd2; phase_next = tsdlp_pkg::P_A1;
                    end
                    tsdlp_pkg::P_A1:
                    begin
                        res[0].id = tsdlp_pkg::F_BRATE; res[0].value = {18'd0, b[7:2]};
                        res[1].id = tsdlp_pkg::F_SURR;  res[1].value = {22'd0, b[1:0]};
                        n = 2'd2; phase_next = tsdlp_pkg::P_A2;
                    end
                    tsdlp_pkg::P_A2:
                    begin
                        res[0].id = tsdlp_pkg::F_BSMOD;   res[0].value = {21'd0, b[7:5]};
                        res[1].id = tsdlp_pkg::F_NCH;     res[1].value = {20'd0, b[4:1]};
                        res[2].id = tsdlp_pkg::F_FULLSVC; res[2].value = {23'd0, b[0]};
                        n = 2'd3;
                        flags_next = {1'b0, (b[7:5] < 3'd2), (b[4:1] == 4'd0)};
                        phase_next = tsdlp_pkg::P_A3;
                    end
                    tsdlp_pkg::P_A3:
                    begin
                        res[0].id = tsdlp_pkg::F_LANGCOD; res[0].value = {16'd0, b};
                        n = 2'd1;
                        phase_next = flags_reg[0] ? tsdlp_pkg::P_A4 : tsdlp_pkg::P_A5;
                    end
                    tsdlp_pkg::P_A4:
                    begin
                        res[0].id = tsdlp_pkg::F_LANGCOD2; res[0].value = {16'd0, b};
                        n = 2'd1; phase_next = tsdlp_pkg::P_A5;
                    end
                    tsdlp_pkg::P_A5:
                    begin
                        if (flags_reg[1])
                        begin
                            res[0].id = tsdlp_pkg::F_MAINID; res[0].value = {21'd0, b[7:5]};
                            res[1].id = tsdlp_pkg::F_PRIO;   res[1].value = {22'd0, b[4:3]};
                            n = 2'd2;
                        end
                        else
                        begin
                            res[0].id = tsdlp_pkg::F_ASVC; res[0].value = {16'd0, b};
                            n = 2'd1;
                        end
                        phase_next = tsdlp_pkg::P_A6;
                    end
                    tsdlp_pkg::P_A6:
                    begin
                        res[0].id = tsdlp_pkg::F_TEXTLEN;  res[0].value = {17'd0, b[7:1]};
                        res[1].id = tsdlp_pkg::F_TEXTCODE; res[1].value = {23'd0, b[0]};
                        n = 2'd2;
                        sbl_next = {1'b0, b[7:1]};
                        phase_next = (b[7:1] != 7'd0) ? tsdlp_pkg::P_ATXT : tsdlp_pkg::P_A7;
                    end
                    tsdlp_pkg::P_ATXT:
                    begin
                        res[0].id = tsdlp_pkg::F_DATA; res[0].value = {16'd0, b};
                        n = 2'd1;
                        sbl_next = sbl_reg - 8'd1;
                        if (sbl_reg == 8'd1) phase_next = tsdlp_pkg::P_A7;
                    end
                    tsdlp_pkg::P_A7:
                    begin
                        res[0].id = tsdlp_pkg::F_LFLAG;  res[0].value = {23'd0, b[7]};
                        res[1].id = tsdlp_pkg::F_LFLAG2; res[1].value = {23'd0, b[6]};
                        n = 2'd2;
                        flags_next = {b[7], b[6], 1'b0};
                        if (b[7])
                        begin
                            entry_next = 8'd0; phase_next = tsdlp_pkg::P_AL0;
                        end
                        else if (b[6])
                        begin
                            entry_next = 8'd1; phase_next = tsdlp_pkg::P_AL0;
                        end
                        else
                        begin
                            phase_next = tsdlp_pkg::P_SKIP;
                        end
                    end
                    tsdlp_pkg::P_AL2:
                    begin
                        accum_next = shifted;
                        res[0].id = tsdlp_pkg::F_AC3LANG; res[0].value = shifted;
                        res[0].entry = entry_reg; n = 2'd1;
                        if (entry_reg == 8'd0 && flags_reg[1])
                        begin
                            entry_next = 8'd1; phase_next = tsdlp_pkg::P_AL0;
                        end
                        else
                        begin
                            phase_next = tsdlp_pkg::P_SKIP;
                        end
                    end
                    tsdlp_pkg::P_CNS:
                    begin
                        res[0].id = tsdlp_pkg::F_NSTR; res[0].value = {16'd0, b};
                        n = 2'd1;
                        strl_next = b; entry_next = 8'd0;
                        phase_next = (b != 8'd0) ? tsdlp_pkg::P_CL0 : tsdlp_pkg::P_SKIP;
                    end
                    tsdlp_pkg::P_CL2:
                    begin
                        accum_next = shifted;
                        res[0].id = tsdlp_pkg::F_SLANG; res[0].value = shifted;
                        res[0].entry = entry_reg; n = 2'd1;
                        phase_next = tsdlp_pkg::P_CSEG;
                    end
                    tsdlp_pkg::P_CSEG, tsdlp_pkg::P_CNB, tsdlp_pkg::P_CBYTES:
                    begin
                        res[0].value = {16'd0, b}; res[0].entry = entry_reg;
                        n = 2'd1;
                        // end of segment or string, shared by the three phases
                        unique case (ph)
                            tsdlp_pkg::P_CSEG:
                            begin
                                res[0].id = tsdlp_pkg::F_NSEG;
                                segl_next = b;
                                tmp8 = b;
                            end
                            tsdlp_pkg::P_CNB:
                            begin
                                res[0].id = tsdlp_pkg::F_NBYTES;
                                sbl_next = b;
                                tmp8 = b;
                            end
                            default:
                            begin
                                res[0].id = tsdlp_pkg::F_DATA;
                                sbl_next = sbl_reg - 8'd1;
                                tmp8 = sbl_reg - 8'd1;
                            end
                        endcase
                        if (tmp8 != 8'd0)
                        begin
                            if (ph == tsdlp_pkg::P_CSEG)      phase_next = tsdlp_pkg::P_CCT;
                            else if (ph == tsdlp_pkg::P_CNB)  phase_next = tsdlp_pkg::P_CBYTES;
                        end
                        else if (ph != tsdlp_pkg::P_CSEG && segl_reg != 8'd1)
                        begin
                            segl_next  = segl_reg - 8'd1;
                            phase_next = tsdlp_pkg::P_CCT;
                        end
                        else
                        begin
                            if (ph != tsdlp_pkg::P_CSEG) segl_next = segl_reg - 8'd1;
                            strl_next  = strl_reg - 8'd1;
                            entry_next = entry_reg + 8'd1;
                            phase_next = (strl_reg != 8'd1) ? tsdlp_pkg::P_CL0
                                                            : tsdlp_pkg::P_SKIP;
                        end
                    end
                    tsdlp_pkg::P_CCT:
                    begin
                        res[0].id = tsdlp_pkg::F_CTYPE; res[0].value = {16'd0, b};
                        res[0].entry = entry_reg; n = 2'd1;
                        phase_next = tsdlp_pkg::P_CMODE;
                    end
                    tsdlp_pkg::P_CMODE:
                    begin
                        res[0].id = tsdlp_pkg::F_MODE; res[0].value = {16'd0, b};
                        res[0].entry = entry_reg; n = 2'd1;
                        phase_next = tsdlp_pkg::P_CNB;
                    end
                    default:
                    begin
                        res[0].id = tsdlp_pkg::F_DATA; res[0].value = {16'd0, b};
                        n = 2'd1; phase_next = tsdlp_pkg::P_SKIP;
                    end
                endcase
                if (dleft_dec != 8'd0) desc_left_next = dleft_dec - 8'd1;
                else                   desc_left_next = 8'd0;
                if (desc_left_next == 8'd0) done = 1'b1;
            end

            if (ll_dec == 12'd0) done = 1'b1;

            if (done)
            begin
                if (n == 2'd0)
                begin
                    res[0] = '{tsdlp_pkg::F_DATA, {16'd0, b}, cur_tag_next, 8'd0,
                               1'b0, 1'b0, 1'b0};
                    n = 2'd1;
                end
                phase_next     = tsdlp_pkg::P_TAG;
                desc_left_next = 8'd0;
            end
            // flag the last result of this byte
            if (n != 2'd0)
            begin
                res[n - 2'd1].run_last = 1'b1;
                res[n - 2'd1].desc_end = done;
                res[n - 2'd1].loop_end = (ll_dec == 12'd0);
            end
        end
        else if (in_valid)
        begin
            // loop_start with zero length still resets the parse position
            loop_left_next = ll;
            phase_next     = ph;
            desc_left_next = dleft_dec;
        end
    end

    // hold parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_left_reg <= '0;
            cur_tag_reg   <= '0;
            desc_left_reg <= '0;
            phase_reg     <= tsdlp_pkg::P_TAG;
            accum_reg     <= '0;
            strl_reg      <= '0;
            segl_reg      <= '0;
            sbl_reg       <= '0;
            entry_reg     <= '0;
            flags_reg     <= '0;
        end
        else if (in_valid)
        begin
            loop_left_reg <= loop_left_next;
            cur_tag_reg   <= cur_tag_next;
            desc_left_reg <= desc_left_next;
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            strl_reg      <= strl_next;
            segl_reg      <= segl_next;
            sbl_reg       <= sbl_next;
            entry_reg     <= entry_next;
            flags_reg     <= flags_next;
        end
    end

    // queue only bytes that produce at least one result
    assign grp_valid = active && (n != 2'd0);
    assign grp.count = n;
    assign grp.r0    = res[0];
    assign grp.r1    = res[1];
    assign grp.r2    = res[2];

endmodule

// ===== rtl/tsdlp_queue.sv =====
// Short group queue between the parser front and the result back end.
// Depends on tsdlp_pkg.
module tsdlp_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  tsdlp_pkg::group_t     wr_data,
    output logic                  full,
    output logic                  q_empty,
    input  logic                  rd_en,
    output tsdlp_pkg::group_t     rd_data
);

    tsdlp_pkg::group_t                   mem [tsdlp_pkg::QDEPTH];
    logic [tsdlp_pkg::QPTRW-1:0]         wp_reg, rp_reg;
    logic [tsdlp_pkg::QPTRW:0]           cnt_reg;

    assign full    = (cnt_reg == 3'(tsdlp_pkg::QDEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_data = mem[rp_reg];

    // store a group
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wp_reg] <= wr_data;
        end
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en) wp_reg <= wp_reg + 1'b1;
            if (rd_en) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {2'd0, wr_en} - {2'd0, rd_en};
        end
    end

endmodule

// ===== rtl/tsdlp_back.sv =====
// Back end: unpacks each queued group into single result beats.
// Depends on tsdlp_pkg.
module tsdlp_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  tsdlp_pkg::group_t     q_data,
    output logic                  q_rd,
    output logic                  empty,
    input  logic                  pop,
    output tsdlp_pkg::result_t    res
);

    logic [1:0] idx_reg;
    logic       last;

    // select the current result of the head group
    always_comb
    begin
        unique case (idx_reg)
            2'd0:    res = q_data.r0;
            2'd1:    res = q_data.r1;
            default: res = q_data.r2;
        endcase
    end

    assign empty = q_empty;
    assign last  = (idx_reg + 2'd1 == q_data.count);
    assign q_rd  = pop && !q_empty && last;

    // step through the group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (pop && !q_empty)
        begin
            idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

// ===== rtl/ts_descriptor_loop_parser.sv =====
// Top level of the transport-stream descriptor loop parser.
// Depends on tsdlp_pkg, tsdlp_front, tsdlp_queue, tsdlp_back.
//
// Usage:
//   Input channel (push/full) takes one loop byte per beat; loop_start marks
//   the first byte of a loop and loop_length is sampled with it.
//   Result channel (empty/pop) shows the oldest result while empty is low;
//   each byte yields zero to three results, run_last marks the final one.
//   Config channel (cfg_valid/cfg_ready) writes one 8-bit tag register per
//   beat; cfg_ready is always high. Write only while the block is idle.
// Path: results are written into the group queue and read from its head.
// Throughput: one byte per cycle while full is low, set by the parse state
//   machine; results drain at one per cycle while pop is high, so bytes giving
//   two or three results drain at that rate through a four-group queue.
// Reset: parse state clears to "outside a loop", tag registers return to
//   their defaults, the queue empties.
// Stall: when pop stays low the queue fills and full rises; no beat is lost.
module ts_descriptor_loop_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        loop_start,
    input  logic [11:0] loop_length,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  field_id,
    output logic [23:0] field_value,
    output logic [7:0]  desc_tag,
    output logic [7:0]  entry_index,
    output logic        desc_end,
    output logic        loop_end,
    output logic        run_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]         lang_reg, ca_reg, mb_reg, ac3_reg, cn_reg;
    logic               acc;
    logic               grp_valid;
    tsdlp_pkg::group_t  grp, q_data;
    logic               q_empty, q_rd;
    tsdlp_pkg::result_t res;

    assign cfg_ready = 1'b1;
    assign acc       = push && !full;

    // hold tag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lang_reg <= 8'd10;
            ca_reg   <= 8'd9;
            mb_reg   <= 8'd14;
            ac3_reg  <= 8'd129;
            cn_reg   <= 8'd163;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tsdlp_pkg::REG_LANG: lang_reg <= cfg_data;
                tsdlp_pkg::REG_CA:   ca_reg   <= cfg_data;
                tsdlp_pkg::REG_MB:   mb_reg   <= cfg_data;
                tsdlp_pkg::REG_AC3:  ac3_reg  <= cfg_data;
                tsdlp_pkg::REG_CN:   cn_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    tsdlp_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(acc),
        .data_byte(data_byte), .loop_start(loop_start), .loop_length(loop_length),
        .language_tag(lang_reg), .cond_access_tag(ca_reg), .max_rate_tag(mb_reg),
        .ac3_tag(ac3_reg), .comp_name_tag(cn_reg),
        .grp_valid(grp_valid), .grp(grp)
    );

    tsdlp_queue u_queue
    (
        .clk(clk), .rst_n(rst_n), .wr_en(grp_valid), .wr_data(grp),
        .full(full), .q_empty(q_empty), .rd_en(q_rd), .rd_data(q_data)
    );

    tsdlp_back u_back
    (
        .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(q_data),
        .q_rd(q_rd), .empty(empty), .pop(pop), .res(res)
    );

    assign field_id    = res.id;
    assign field_value = res.value;
    assign desc_tag    = res.tag;
    assign entry_index = res.entry;
    assign desc_end    = res.desc_end;
    assign loop_end    = res.loop_end;
    assign run_last    = res.run_last;

endmodule

// ===== rtl/tsdlp_checker.sv =====
// Port-level checker for the descriptor loop parser, bound to the top level.
// Depends on the top level's ports and the field ids in tsdlp_pkg.
module tsdlp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic [4:0] field_id,
    input logic       desc_end,
    input logic       loop_end,
    input logic       run_last
);

    // a held result does not change while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(field_id) && $stable(run_last)))
        else $error("result changed while stalled");

    // loop end always closes the descriptor
    a_loop_desc: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && loop_end) |-> desc_end)
        else $error("loop_end without desc_end");

    // descriptor end only on the last result of a byte
    a_desc_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && desc_end) |-> run_last)
        else $error("desc_end not on last result");

    // overrun is always the last result of its byte
    a_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && field_id == tsdlp_pkg::F_OVERRUN) |-> run_last)
        else $error("overrun not on last result");

endmodule

bind ts_descriptor_loop_parser tsdlp_checker u_tsdlp_checker
(
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty), .pop(pop),
    .field_id(field_id), .desc_end(desc_end), .loop_end(loop_end), .run_last(run_last)
);
